@@ hdl/poisson_deviance_accumulator_macros.svh @@
// assertion macros shared by the rtl files
`ifndef POISSON_DEVIANCE_ACCUMULATOR_MACROS_SVH
`define POISSON_DEVIANCE_ACCUMULATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PDA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PDA_ASSERT(lbl, prop, msg)
`define PDA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/pda_pkg.sv @@
package pda_pkg;

	localparam int DEFAULT_LN_ITERATIONS = 16;
	localparam int SUM_W = 48;
	localparam int ADD_W = 40;
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic [15:0] E_LOW_CUT_RST = 16'd410;
	localparam logic [15:0] E_HIGH_CUT_RST = 16'd4915;
	localparam logic [15:0] MU_LOW_CUT_RST = 16'd819;

	typedef enum logic [1:0] {
		REG_E_LOW_CUT = 2'd0,
		REG_E_HIGH_CUT = 2'd1,
		REG_HIGH_CUT_EN = 2'd2,
		REG_MU_LOW_CUT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_ZERO_D,
		CLS_BOTH
	} cls_t;

	typedef struct packed {
		cls_t cls;
		logic [31:0] observed;
		logic [31:0] predicted;
		logic last;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOG,
		ST_LN,
		ST_TERM,
		ST_CLAMP,
		ST_ACC
	} state_t;

	function automatic logic [4:0] msb_pos(input logic [31:0] x);
		logic [4:0] k;
		k = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				k = 5'(i);
			end
		end
		return k;
	endfunction

endpackage

@@ hdl/pda_front.sv @@
`include "poisson_deviance_accumulator_macros.svh"

module pda_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                sample_kind,
	input  logic [15:0]         bin_energy,
	input  logic [31:0]         observed,
	input  logic [31:0]         predicted,
	input  logic                last,
	output logic                head_valid,
	output pda_pkg::entry_t     head,
	input  logic                pop
);

	logic [15:0] e_low_q, e_high_q, mu_low_q;
	logic        high_en_q;
	pda_pkg::entry_t fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, keep;
	pda_pkg::entry_t new_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_low_q   <= pda_pkg::E_LOW_CUT_RST;
			e_high_q  <= pda_pkg::E_HIGH_CUT_RST;
			high_en_q <= 1'b1;
			mu_low_q  <= pda_pkg::MU_LOW_CUT_RST;
		end else if (cfg_valid) begin
			unique case (pda_pkg::reg_idx_t'(cfg_index))
				pda_pkg::REG_E_LOW_CUT:   e_low_q   <= cfg_data;
				pda_pkg::REG_E_HIGH_CUT:  e_high_q  <= cfg_data;
				pda_pkg::REG_HIGH_CUT_EN: high_en_q <= cfg_data[0];
				pda_pkg::REG_MU_LOW_CUT:  mu_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// energy cuts and count classification
	always_comb begin
		if (sample_kind) begin
			keep = !(bin_energy < mu_low_q);
		end else begin
			keep = !(bin_energy < e_low_q) && !(bin_energy > e_high_q && high_en_q);
		end
		new_entry.observed  = observed;
		new_entry.predicted = predicted;
		new_entry.last      = last;
		if (!keep) begin
			new_entry.cls = pda_pkg::CLS_NONE;
		end else if (observed == '0) begin
			new_entry.cls = pda_pkg::CLS_ZERO_D;
		end else if (predicted != '0) begin
			new_entry.cls = pda_pkg::CLS_BOTH;
		end else begin
			new_entry.cls = pda_pkg::CLS_NONE;
		end
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`PDA_ASSERT_NEVER(a_fifo_over, count_q > 2'd2, "queue count beyond depth")
	`PDA_ASSERT_NEVER(a_pop_empty, pop && count_q == 2'd0, "pop from empty queue")
	`PDA_ASSERT(a_push_count, push && !pop |=> count_q == $past(count_q) + 2'd1, "push lost")

endmodule

@@ hdl/pda_back.sv @@
`include "poisson_deviance_accumulator_macros.svh"

module pda_back #(
	parameter int LN_ITERATIONS = pda_pkg::DEFAULT_LN_ITERATIONS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  pda_pkg::entry_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [47:0]     total_deviance,
	output logic            saturated
);

	localparam int CntW = (LN_ITERATIONS > 1) ? $clog2(LN_ITERATIONS) : 1;

	pda_pkg::state_t state_q, state_d;
	logic [31:0] d_q, p_q;
	logic        last_q;
	logic [31:0] md_q, mp_q, fd_q, fp_q;
	logic [4:0]  kd_q, kp_q;
	logic [CntW-1:0] cnt_q;
	logic [37:0] lnm_q;
	logic        neg_q;
	logic [38:0] t_q;
	logic [pda_pkg::ADD_W-1:0] add_q;
	logic [47:0] sum_q;
	logic        ovf_q;
	logic        out_valid_q;
	logic [47:0] total_q;
	logic        sat_q;

	logic        acc_go, log_done, report;
	logic [4:0]  hkd, hkp;
	logic [63:0] sqd, sqp;
	logic [36:0] ld, lp, dm;
	logic [36:0] pr_hi;
	logic [63:0] pr_lo;
	logic [38:0] tm_hi;
	logic [63:0] tm_lo;
	logic signed [40:0] inner;
	logic [48:0] sum_ext;
	logic [47:0] sum_new;

	assign log_done = (cnt_q == CntW'(LN_ITERATIONS - 1));
	assign hkd = pda_pkg::msb_pos(head.observed);
	assign hkp = pda_pkg::msb_pos(head.predicted);
	assign report = (state_q == pda_pkg::ST_ACC) && acc_go && last_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pda_pkg::ST_IDLE: begin
				if (head_valid) begin
					state_d = (head.cls == pda_pkg::CLS_BOTH) ? pda_pkg::ST_LOG
						: pda_pkg::ST_ACC;
				end
			end
			pda_pkg::ST_LOG:   if (log_done) state_d = pda_pkg::ST_LN;
			pda_pkg::ST_LN:    state_d = pda_pkg::ST_TERM;
			pda_pkg::ST_TERM:  state_d = pda_pkg::ST_CLAMP;
			pda_pkg::ST_CLAMP: state_d = pda_pkg::ST_ACC;
			pda_pkg::ST_ACC:   if (acc_go) state_d = pda_pkg::ST_IDLE;
			default:           state_d = pda_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop    = 1'b0;
		acc_go = 1'b0;
		unique case (state_q)
			pda_pkg::ST_IDLE: pop = head_valid;
			pda_pkg::ST_ACC:  acc_go = !(last_q && out_valid_q && !out_ready);
			default: ;
		endcase
	end

	// datapath arithmetic
	always_comb begin
		sqd   = 64'(md_q) * 64'(md_q);
		sqp   = 64'(mp_q) * 64'(mp_q);
		ld    = {kd_q, fd_q};
		lp    = {kp_q, fp_q};
		dm    = (ld < lp) ? lp - ld : ld - lp;
		pr_hi = 37'(dm[36:32]) * 37'(pda_pkg::LN2_Q32);
		pr_lo = 64'(dm[31:0]) * 64'(pda_pkg::LN2_Q32);
		tm_hi = 39'(d_q) * 39'(lnm_q[37:32]);
		tm_lo = 64'(d_q) * 64'(lnm_q[31:0]);
		inner = $signed({9'b0, p_q}) - $signed({9'b0, d_q});
		if (neg_q) begin
			inner = inner - $signed({2'b0, t_q});
		end else begin
			inner = inner + $signed({2'b0, t_q});
		end
		sum_ext = {1'b0, sum_q} + 49'(add_q);
		sum_new = sum_ext[48] ? '1 : sum_ext[47:0];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pda_pkg::ST_IDLE: begin
				d_q    <= head.observed;
				p_q    <= head.predicted;
				last_q <= head.last;
				md_q   <= head.observed << (5'd31 - hkd);
				mp_q   <= head.predicted << (5'd31 - hkp);
				kd_q   <= hkd;
				kp_q   <= hkp;
				fd_q   <= '0;
				fp_q   <= '0;
				cnt_q  <= '0;
				add_q  <= (head.cls == pda_pkg::CLS_ZERO_D) ?
					{7'b0, head.predicted, 1'b0} : '0;
			end
			pda_pkg::ST_LOG: begin
				cnt_q <= cnt_q + CntW'(1);
				if (sqd[63]) begin
					md_q <= sqd[63:32];
					fd_q[5'd31 - 5'(cnt_q)] <= 1'b1;
				end else begin
					md_q <= sqd[62:31];
				end
				if (sqp[63]) begin
					mp_q <= sqp[63:32];
					fp_q[5'd31 - 5'(cnt_q)] <= 1'b1;
				end else begin
					mp_q <= sqp[62:31];
				end
			end
			pda_pkg::ST_LN: begin
				neg_q <= (ld < lp);
				lnm_q <= 38'(pr_hi) + 38'(pr_lo[63:32]);
			end
			pda_pkg::ST_TERM: begin
				t_q <= tm_hi + 39'(tm_lo[63:32]);
			end
			pda_pkg::ST_CLAMP: begin
				add_q <= inner[40] ? '0 : {inner[38:0], 1'b0};
			end
			default: ;
		endcase
		if (report) begin
			total_q <= sum_new;
			sat_q   <= ovf_q | sum_ext[48];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pda_pkg::ST_IDLE;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (report) begin
				sum_q       <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (state_q == pda_pkg::ST_ACC && acc_go) begin
					sum_q <= sum_new;
					ovf_q <= ovf_q | sum_ext[48];
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign total_deviance = total_q;
	assign saturated      = sat_q;

	`PDA_ASSERT(a_last_reports, report |=> out_valid_q, "last word not reported")
	`PDA_ASSERT(a_last_clears, report |=> sum_q == '0 && !ovf_q, "sum not cleared")
	`PDA_ASSERT_NEVER(a_pop_busy, pop && state_q != pda_pkg::ST_IDLE, "pop while busy")

endmodule

@@ hdl/poisson_deviance_accumulator.sv @@
// Poisson deviance accumulator. Bins enter on the in channel into a two-word queue after the
// energy cuts are applied; a back end works through one word at a time. A bin whose observed and
// predicted counts are both nonzero runs the squaring loop of the log2 unit (one squaring per
// cycle for both counts), then the ln, term and clamp states; every other bin goes straight
// to accumulate. The sum is reported on the out channel on each last bin and then cleared.
// Config writes (index 0..3: e_low_cut, e_high_cut, high_cut_enable, mu_low_cut) are always ready.
module poisson_deviance_accumulator #(
	parameter int LN_ITERATIONS = pda_pkg::DEFAULT_LN_ITERATIONS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        sample_kind,
	input  logic [15:0] bin_energy,
	input  logic [31:0] observed,
	input  logic [31:0] predicted,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] total_deviance,
	output logic        saturated
);

	logic            head_valid;
	pda_pkg::entry_t head;
	logic            pop;

	assign cfg_ready = 1'b1;

	pda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_kind(sample_kind),
		.bin_energy (bin_energy),
		.observed   (observed),
		.predicted  (predicted),
		.last       (last),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	pda_back #(
		.LN_ITERATIONS(LN_ITERATIONS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.total_deviance(total_deviance),
		.saturated     (saturated)
	);

endmodule
